// File: src/rc_pkg.sv
// Radix converter package: payload types, status codes, widths and character maps.
`default_nettype none

package rc_pkg;

  localparam int unsigned ACC_W     = 64;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned BASE_W    = 5;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned VAL_W     = 6;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = ACC_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0]  CNT_SAT   = 5'd31;
  localparam logic [VAL_W-1:0]  BAD_DIGIT = 6'd31;
  localparam logic [BASE_W-1:0] MIN_BASE  = 5'd2;
  localparam logic [BASE_W-1:0] MAX_BASE  = 5'd16;
  localparam logic [CHAR_W-1:0] DEC_RADIX = 8'd10;

  localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ = 8'h7A;

  typedef enum logic [1:0] {
    RC_ST_OK       = 2'd0,
    RC_ST_ILLEGAL  = 2'd1,
    RC_ST_TOO_LONG = 2'd2
  } rc_status_e;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic [BASE_W-1:0] src_base;
    logic [BASE_W-1:0] dst_base;
    logic              is_last;
  } rc_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic [1:0]        status;
    logic              last_out;
  } rc_out_t;

  function automatic logic [VAL_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [VAL_W-1:0] v;
    if (c inside {[CH_0:CH_9]}) begin
      v = VAL_W'(c - CH_0);
    end else if (c inside {[CH_UA:CH_UF]}) begin
      v = VAL_W'(c - CH_UA + DEC_RADIX);
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      v = VAL_W'(c - CH_LA + DEC_RADIX);
    end else begin
      v = BAD_DIGIT;
    end
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (CHAR_W'(d) < DEC_RADIX) begin
      c = CH_0 + CHAR_W'(d);
    end else begin
      c = CH_UA + CHAR_W'(d) - DEC_RADIX;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/rc_divider.sv
// Iterative divider: 64-bit value by a small base, four quotient bits per cycle.
`default_nettype none

module rc_divider import rc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [ACC_W-1:0]   dividend_i,
  input  wire logic [BASE_W-1:0]  divisor_i,
  output      logic               done_o,
  output      logic [ACC_W-1:0]   quot_o,
  output      logic [DIGIT_W-1:0] rem_o
);

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0]     work_q, work_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic [BASE_W-1:0]    div_q;
  logic [BASE_W-1:0]    trial;

  // restoring long division, dividend bits shift out the top, quotient bits in the bottom
  always_comb begin
    rem_d  = rem_q;
    work_d = work_q;
    trial  = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial  = {rem_d, work_d[ACC_W-1]};
      work_d = {work_d[ACC_W-2:0], 1'b0};
      if (trial >= div_q) begin
        trial     = trial - div_q;
        work_d[0] = 1'b1;
      end
      rem_d = trial[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (run_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = work_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: src/rc_digit_buf.sv
// Digit buffer: one write port, one registered read port.
`default_nettype none

module rc_digit_buf import rc_pkg::*; #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [ADDR_W-1:0]  waddr_i,
  input  wire logic [DIGIT_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]  raddr_i,
  output      logic [DIGIT_W-1:0] rdata_o
);

  logic [DIGIT_W-1:0] mem_q [DEPTH];
  logic [DIGIT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/radix_converter_core.sv
// Radix converter top level: digit accumulation, conversion sequencer and result register.
// A character that is not the last is taken into the accumulator; busy stays low.
// A last character that ends in a status result gives it in the cycle after the transfer.
// Otherwise each target digit takes a pass of the shared divider (16 steps of 4 bits),
// then the digits leave one per cycle from the emit state through the result register.
// Reset (asynchronous, active low) clears accumulator, flags, count and sequencer; the
// result strobe is a single cycle and the receiver cannot stall it.
`default_nettype none

module radix_converter_core import rc_pkg::*; #(
  parameter int unsigned MAX_IN_DIGITS  = 16,
  parameter int unsigned MAX_OUT_DIGITS = 64
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output      logic    busy,
  input  wire rc_in_t  item_i,
  output      logic    result_valid_o,
  output      rc_out_t result_o
);

  localparam int unsigned PTR_W = $clog2(MAX_OUT_DIGITS);
  localparam int unsigned LEN_W = $clog2(MAX_OUT_DIGITS + 1);

  // one-hot sequencer
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } rc_state_e;

  rc_state_e state_q, state_d;

  // accumulation state
  logic [ACC_W-1:0]  acc_q;
  logic              ill_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [BASE_W-1:0] db_q;

  // conversion state
  logic [LEN_W-1:0]  len_q;
  logic [PTR_W-1:0]  ptr_q;

  // result register
  logic              res_vld_q;
  rc_status_e        res_st_q;
  logic              res_last_q;

  // per-character decode
  logic              xfer;
  logic [VAL_W-1:0]  val;
  logic              legal;
  logic              ill_now;
  logic [CNT_W-1:0]  cnt_inc;
  logic              too_long;
  logic [ACC_W+BASE_W-1:0] prod;
  logic [ACC_W-1:0]  acc_new;
  logic [BASE_W-1:0] db_sat;

  // divider hookup
  logic               div_start;
  logic [ACC_W-1:0]   div_dividend;
  logic [BASE_W-1:0]  div_divisor;
  logic               div_done;
  logic [ACC_W-1:0]   div_quot;
  logic [DIGIT_W-1:0] div_rem;
  logic               quot_zero;
  logic               out_full;

  // buffer hookup
  logic               buf_we;
  logic [DIGIT_W-1:0] buf_rdata;

  assign busy = (state_q != ST_IDLE);
  assign xfer = start && !busy;

  assign val      = char_value(item_i.digit_char);
  assign legal    = val < VAL_W'(item_i.src_base);
  assign ill_now  = ill_q || !legal;
  assign cnt_inc  = (cnt_q != CNT_SAT) ? cnt_q + 1'b1 : cnt_q;
  assign too_long = cnt_inc > CNT_W'(MAX_IN_DIGITS);
  assign prod     = acc_q * item_i.src_base;
  assign acc_new  = legal ? prod[ACC_W-1:0] + ACC_W'(val) : acc_q;

  // target base clamped into 2..16
  always_comb begin
    if (item_i.dst_base < MIN_BASE) begin
      db_sat = MIN_BASE;
    end else if (item_i.dst_base > MAX_BASE) begin
      db_sat = MAX_BASE;
    end else begin
      db_sat = item_i.dst_base;
    end
  end

  assign quot_zero = (div_quot == '0);
  assign out_full  = (len_q + 1'b1) == LEN_W'(MAX_OUT_DIGITS);
  assign buf_we    = (state_q == ST_DIV) && div_done;

  // first divide starts from the freshly accumulated value, later ones from the quotient
  always_comb begin
    div_start    = 1'b0;
    div_dividend = div_quot;
    div_divisor  = db_q;
    case (state_q)
      ST_IDLE: begin
        div_dividend = acc_new;
        div_divisor  = db_sat;
        div_start    = xfer && item_i.is_last && !ill_now && !too_long;
      end
      ST_DIV: begin
        div_start = div_done && !quot_zero && !out_full;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (div_start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done && quot_zero) begin
          state_d = ST_EMIT;
        end else if (div_done && out_full) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (ptr_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      acc_q      <= '0;
      ill_q      <= 1'b0;
      cnt_q      <= '0;
      db_q       <= MIN_BASE;
      len_q      <= '0;
      ptr_q      <= '0;
      res_vld_q  <= 1'b0;
      res_st_q   <= RC_ST_OK;
      res_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (xfer) begin
            if (item_i.is_last) begin
              // run ends here: clear accumulation, decide status or conversion
              acc_q <= '0;
              ill_q <= 1'b0;
              cnt_q <= '0;
              db_q  <= db_sat;
              len_q <= '0;
              if (ill_now) begin
                res_vld_q  <= 1'b1;
                res_st_q   <= RC_ST_ILLEGAL;
                res_last_q <= 1'b1;
              end else if (too_long) begin
                res_vld_q  <= 1'b1;
                res_st_q   <= RC_ST_TOO_LONG;
                res_last_q <= 1'b1;
              end
            end else begin
              acc_q <= acc_new;
              ill_q <= ill_now;
              cnt_q <= cnt_inc;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            len_q <= len_q + 1'b1;
            ptr_q <= len_q[PTR_W-1:0];
            if (!quot_zero && out_full) begin
              // more digits than the buffer holds
              res_vld_q  <= 1'b1;
              res_st_q   <= RC_ST_TOO_LONG;
              res_last_q <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          // read issued now, digit shows with the strobe next cycle
          res_vld_q  <= 1'b1;
          res_st_q   <= RC_ST_OK;
          res_last_q <= (ptr_q == '0);
          ptr_q      <= ptr_q - 1'b1;
        end
        default: begin
          res_vld_q <= 1'b0;
        end
      endcase
    end
  end

  rc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  rc_digit_buf #(
    .DEPTH  (MAX_OUT_DIGITS),
    .ADDR_W (PTR_W)
  ) u_digit_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (len_q[PTR_W-1:0]),
    .wdata_i (div_rem),
    .raddr_i (ptr_q),
    .rdata_o (buf_rdata)
  );

  assign result_valid_o    = res_vld_q;
  assign result_o.out_char = (res_st_q != RC_ST_OK) ? '0 : digit_char_of(buf_rdata);
  assign result_o.status   = res_st_q;
  assign result_o.last_out = res_last_q;

endmodule

`default_nettype wire
